@@ sv/yaz0_pkg.sv @@
// yaz0_pkg: shared types and constants for the yaz0 stream decompressor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package yaz0_pkg;
  localparam int unsigned HistAw = 12;
  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusBadRef = 2'd1;
  localparam logic [1:0] StatusPastEnd = 2'd2;
  localparam logic [7:0] LitFlagMask = 8'h80;
  localparam logic [7:0] NibbleMask = 8'h0F;
  localparam logic [8:0] LongLenBias = 9'h012;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_stream;
  } in_word_t;
endpackage
`default_nettype wire

@@ sv/yaz0_if.sv @@
// yaz0_in_if / yaz0_out_if / yaz0_cfg_if: valid-ready channels
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface yaz0_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_stream;
  modport source (output valid, in_byte, start_of_stream, input ready);
  modport sink (input valid, in_byte, start_of_stream, output ready);
endinterface

interface yaz0_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        last_of_item;
  logic        stream_end;
  logic [1:0]  status;
  modport source (output valid, out_bytes, byte_count, last_of_item, stream_end, status,
                  input ready);
  modport sink (input valid, out_bytes, byte_count, last_of_item, stream_end, status,
                output ready);
endinterface

interface yaz0_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ sv/yaz0_stream_decompressor.sv @@
// yaz0_stream_decompressor: top level, byte sequencer with 4096-byte history ram
// depends on yaz0_pkg and the channel interfaces in yaz0_if.sv
//
// usage: compressed payload words enter on in_ch, one byte each; start_of_stream
// restarts the counters and group state ahead of that byte. total_size is to be written
// on cfg_ch only while idle; the block itself does not enforce this. results leave on
// out_ch, up to OUT_WORD_BYTES bytes packed with the earliest byte in the lowest lane.
// group bytes and non-final reference bytes are taken in the idle state; a literal
// goes through accept, write and emit; a reference copy moves each byte in a read
// and write pass through the single ram read port (read, then write back), plus an
// emit step per result word.
// a fault or past-end result is registered on accept; a literal result passes the write
// and emit states, and the first word of a copy at least the read, write and emit states.
// in_ch.ready is low while a byte is in work; out_ch stalls hold the sequencer.
// reset clears all control state and total_size; the history ram is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module yaz0_stream_decompressor #(
  parameter int unsigned OUT_WORD_BYTES = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  yaz0_in_if.sink   in_ch,
  yaz0_cfg_if.sink  cfg_ch,
  yaz0_out_if.source out_ch
);
  localparam int unsigned Aw = yaz0_pkg::HistAw;
  localparam int unsigned CntW = $clog2(OUT_WORD_BYTES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_WRITE, S_EMIT, S_DONE
  } state_e;

  state_e       state_q;
  logic [31:0]  total_q, prod_q;
  logic [Aw-1:0] widx_q, src_q;
  logic [7:0]   flags_q, tfirst_q, tsecond_q, lit_q;
  logic [3:0]   left_q;
  logic [1:0]   phase_q;
  logic [8:0]   len_q;
  logic         from_hist_q;
  logic [63:0]  word_q;
  logic [CntW-1:0] cnt_q;
  logic [7:0]   hist_mem [2**Aw];
  logic [7:0]   rd_q;

  logic         ov_q, olast_q, oend_q;
  logic [63:0]  obytes_q;
  logic [3:0]   ocnt_q;
  logic [1:0]   ostat_q;

  logic in_fire, out_free;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_free = !ov_q || out_ch.ready;
  assign in_ch.ready = (state_q == S_IDLE) && out_free;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ov_q;
  assign out_ch.out_bytes = obytes_q;
  assign out_ch.byte_count = ocnt_q;
  assign out_ch.last_of_item = olast_q;
  assign out_ch.stream_end = oend_q;
  assign out_ch.status = ostat_q;

  // byte being written on this pass
  logic [7:0] cur_b;
  assign cur_b = from_hist_q ? rd_q : lit_q;

  always_ff @(posedge clk_i) begin
    rd_q <= hist_mem[src_q];
    if (state_q == S_WRITE) hist_mem[widx_q] <= cur_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0; prod_q <= '0; widx_q <= '0; src_q <= '0;
      flags_q <= '0; left_q <= '0; phase_q <= '0; tfirst_q <= '0; tsecond_q <= '0;
      lit_q <= '0; len_q <= '0; from_hist_q <= 1'b0; word_q <= '0; cnt_q <= '0;
      ov_q <= 1'b0; olast_q <= 1'b0; oend_q <= 1'b0; obytes_q <= '0; ocnt_q <= '0;
      ostat_q <= '0;
    end else begin
      if (out_ch.ready) ov_q <= 1'b0;
      if (cfg_ch.valid) total_q <= cfg_ch.data;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            logic [31:0] pc;
            logic [7:0] fl;
            logic [3:0] lf;
            logic [1:0] ph;
            logic [7:0] tf;
            logic [11:0] d;
            pc = in_ch.start_of_stream ? '0 : prod_q;
            fl = in_ch.start_of_stream ? '0 : flags_q;
            lf = in_ch.start_of_stream ? '0 : left_q;
            ph = in_ch.start_of_stream ? '0 : phase_q;
            tf = in_ch.start_of_stream ? '0 : tfirst_q;
            d = '0;
            if (in_ch.start_of_stream) begin
              prod_q <= '0; widx_q <= '0; tsecond_q <= '0;
            end
            flags_q <= fl; left_q <= lf; phase_q <= ph; tfirst_q <= tf;
            word_q <= '0; cnt_q <= '0;
            if (pc >= total_q) begin
              ov_q <= 1'b1; obytes_q <= '0; ocnt_q <= '0; olast_q <= 1'b1;
              oend_q <= 1'b0; ostat_q <= yaz0_pkg::StatusPastEnd;
            end else if (ph != 2'd0) begin
              logic fin;
              logic [8:0] ln;
              fin = 1'b1;
              ln = 9'(in_ch.in_byte) + yaz0_pkg::LongLenBias;
              if (ph == 2'd1) begin
                tsecond_q <= in_ch.in_byte;
                d = {tf[3:0], in_ch.in_byte};
                if (tf[7:4] != 4'd0) ln = 9'(tf[7:4]) + 9'd2;
                else begin
                  fin = 1'b0; phase_q <= 2'd2;
                end
              end else begin
                d = {tf[3:0], tsecond_q};
              end
              if (fin) begin
                phase_q <= '0;
                flags_q <= {fl[6:0], 1'b0};
                if (lf != 4'd0) left_q <= lf - 4'd1;
                if ({20'd0, d} + 32'd1 > pc) begin
                  ov_q <= 1'b1; obytes_q <= '0; ocnt_q <= '0; olast_q <= 1'b1;
                  oend_q <= 1'b0; ostat_q <= yaz0_pkg::StatusBadRef;
                end else begin
                  src_q <= (in_ch.start_of_stream ? '0 : widx_q) - d - 12'd1;
                  len_q <= ln; from_hist_q <= 1'b1; state_q <= S_READ;
                end
              end
            end else if (lf == 4'd0) begin
              flags_q <= in_ch.in_byte; left_q <= 4'd8;
            end else if ((fl & yaz0_pkg::LitFlagMask) != 8'd0) begin
              flags_q <= {fl[6:0], 1'b0}; left_q <= lf - 4'd1;
              lit_q <= in_ch.in_byte; len_q <= 9'd1; from_hist_q <= 1'b0;
              state_q <= S_WRITE;
            end else begin
              tfirst_q <= in_ch.in_byte; phase_q <= 2'd1;
            end
          end
        end
        S_READ: state_q <= S_WRITE;
        S_WRITE: begin
          logic [CntW-1:0] nc;
          nc = cnt_q + CntW'(1);
          word_q[8*cnt_q +: 8] <= cur_b;
          cnt_q <= nc;
          widx_q <= widx_q + 12'd1;
          src_q <= src_q + 12'd1;
          prod_q <= prod_q + 32'd1;
          len_q <= len_q - 9'd1;
          if (nc == CntW'(OUT_WORD_BYTES) || len_q == 9'd1 || prod_q + 32'd1 >= total_q)
            state_q <= S_EMIT;
          else state_q <= S_READ;
        end
        S_EMIT: begin
          if (out_free) begin
            logic done;
            done = (len_q == 9'd0) || (prod_q >= total_q);
            ov_q <= 1'b1; obytes_q <= word_q; ocnt_q <= 4'(cnt_q); olast_q <= done;
            oend_q <= (prod_q == total_q); ostat_q <= yaz0_pkg::StatusOk;
            word_q <= '0; cnt_q <= '0;
            state_q <= done ? S_IDLE : S_READ;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (ocnt_q <= 4'(OUT_WORD_BYTES))) else $error("byte count too large");
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ostat_q != yaz0_pkg::StatusOk) |-> (ocnt_q == 4'd0 && olast_q))
    else $error("fault result not empty");
endmodule
`default_nettype wire
